>>> hw/rtl/cen_pkg.sv
// Shared types and constants for the 3x3 census transform.
package cen_pkg;

    typedef logic [7:0] t_pix;

    // Both line stores share one address, so they live side by side in one entry.
    typedef struct packed {
        t_pix above2;
        t_pix above;
    } t_lines;

    // Write and read control toward the line store (addresses travel separately).
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_ls_ctl;

    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int POS_OUT_W  = 11;
    localparam int SIZE_MIN   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 1'b1;

    localparam logic [CFG_W-1:0] COLS_RESET = 12'd640;
    localparam logic [CFG_W-1:0] ROWS_RESET = 12'd480;

    // Census code bit positions
    localparam int BIT_UL = 0;
    localparam int BIT_U  = 1;
    localparam int BIT_UR = 2;
    localparam int BIT_L  = 3;
    localparam int BIT_R  = 4;
    localparam int BIT_DL = 5;
    localparam int BIT_D  = 6;
    localparam int BIT_DR = 7;

endpackage

>>> hw/rtl/cen_line_store.sv
// Line store memory: two previous image rows, one entry per column.
module cen_line_store
    import cen_pkg::*;
#(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic          i_clk,
    input  t_ls_ctl       i_ctl,
    input  logic [AW-1:0] i_rd_addr,
    input  logic [AW-1:0] i_wr_addr,
    input  t_lines        i_wr_data,
    output t_lines        o_rd_data
);

    t_lines r_mem [DEPTH];
    t_lines r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/cen_window.sv
// 3x3 window registers and the eight neighbor comparisons.
module cen_window
    import cen_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shift,
    input  t_pix       i_top,
    input  t_pix       i_mid,
    input  t_pix       i_bot,
    output logic [7:0] o_code
);

    // [0..2] two columns back (top, mid, bottom), [3..5] one column back
    t_pix r_win [6];
    t_pix ctr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_shift) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= i_top;
            r_win[4] <= i_mid;
            r_win[5] <= i_bot;
        end
    end

    always_comb begin
        ctr            = r_win[4];
        o_code         = '0;
        o_code[BIT_UL] = (r_win[0] >= ctr);
        o_code[BIT_U]  = (r_win[3] >= ctr);
        o_code[BIT_UR] = (i_top >= ctr);
        o_code[BIT_L]  = (r_win[1] >= ctr);
        o_code[BIT_R]  = (i_mid >= ctr);
        o_code[BIT_DL] = (r_win[2] >= ctr);
        o_code[BIT_D]  = (r_win[5] >= ctr);
        o_code[BIT_DR] = (i_bot >= ctr);
    end

endmodule

>>> hw/rtl/census_transform_3x3.sv
// Top level of the streaming 3x3 census transform.
//
// Usage: pixels enter in raster order on the input channel (i_valid, o_stall,
// i_pixel, i_frame_start); i_frame_start puts the pixel at row 0, column 0.
// One result item leaves on the output channel (o_valid, i_stall) for each
// interior center, when its down-right neighbor has been accepted; border
// centers give no item. Image size is set through i_cfg_we / i_cfg_index /
// i_cfg_data while the block is idle; sizes below 3 or above the maximum clamp.
// Result path: the pixel which completes a result passes the line store read
// stage, then the output register, which drives o_valid.
// Throughput: one pixel per cycle while o_stall is low. The line store takes one
// read and one write per cycle; a read of the entry being written is forwarded.
// Reset: position counters and the window clear, sizes return to 640 x 480.
// Line store contents are not cleared; rows are written before they are read.
// Stall: the output register holds a result while i_stall is high; once the
// item behind it is also waiting, o_stall rises and input stops.
module census_transform_3x3
    import cen_pkg::*;
#(
    parameter int MAX_COLS = 2048,
    parameter int MAX_ROWS = 2048
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_pixel,
    input  logic                 i_frame_start,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_census_code,
    output logic [POS_OUT_W-1:0] o_center_row,
    output logic [POS_OUT_W-1:0] o_center_col,
    output logic                 o_frame_last,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int MW   = (CW > RW) ? CW : RW;
    localparam int CMPW = (MW + 1 > CFG_W + 1) ? MW + 1 : CFG_W + 1;

    // configuration
    logic [CFG_W-1:0] r_cfg_cols;
    logic [CFG_W-1:0] r_cfg_rows;
    logic [CMPW-1:0]  cols_x;
    logic [CMPW-1:0]  rows_x;
    logic [CMPW-1:0]  cols_e;
    logic [CMPW-1:0]  rows_e;

    // position counters
    logic [CW-1:0]   r_col;
    logic [RW-1:0]   r_row;
    logic [CW-1:0]   n_col;
    logic [RW-1:0]   n_row;
    logic [CW-1:0]   c0;
    logic [RW-1:0]   r0;
    logic [CMPW-1:0] c0_x;
    logic [CMPW-1:0] r0_x;
    logic [CMPW-1:0] c0_m1;
    logic [CMPW-1:0] r0_m1;

    // handshake
    logic accept;
    logic out_ready;
    logic s1_go;

    // read stage
    logic                 r_s1_valid;
    logic                 r_s1_emit;
    logic                 r_s1_last;
    t_pix                 r_s1_pix;
    logic [CW-1:0]        r_s1_idx;
    logic [POS_OUT_W-1:0] r_s1_row;
    logic [POS_OUT_W-1:0] r_s1_col;
    logic                 r_fwd;
    t_lines               r_fwd_data;
    t_lines               ls_rd_data;
    t_lines               lines;
    t_lines               wr_data;
    t_ls_ctl              ls_ctl;
    logic [7:0]           code;

    // output register
    logic                 r_o_valid;
    logic [7:0]           r_o_code;
    logic [POS_OUT_W-1:0] r_o_row;
    logic [POS_OUT_W-1:0] r_o_col;
    logic                 r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols <= COLS_RESET;
            r_cfg_rows <= ROWS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_COLS: r_cfg_cols <= i_cfg_data;
                CFG_IMAGE_ROWS: r_cfg_rows <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        cols_x = CMPW'(r_cfg_cols);
        rows_x = CMPW'(r_cfg_rows);
        if (cols_x < CMPW'(SIZE_MIN))      cols_e = CMPW'(SIZE_MIN);
        else if (cols_x > CMPW'(MAX_COLS)) cols_e = CMPW'(MAX_COLS);
        else                               cols_e = cols_x;
        if (rows_x < CMPW'(SIZE_MIN))      rows_e = CMPW'(SIZE_MIN);
        else if (rows_x > CMPW'(MAX_ROWS)) rows_e = CMPW'(MAX_ROWS);
        else                               rows_e = rows_x;
    end

    // position of the incoming pixel and the next one
    always_comb begin
        c0    = i_frame_start ? '0 : r_col;
        r0    = i_frame_start ? '0 : r_row;
        c0_x  = CMPW'(c0);
        r0_x  = CMPW'(r0);
        c0_m1 = c0_x - CMPW'(1);
        r0_m1 = r0_x - CMPW'(1);
        if (c0_x + CMPW'(1) >= cols_e) begin
            n_col = '0;
            n_row = (r0_x + CMPW'(1) >= rows_e) ? '0 : RW'(r0_x + CMPW'(1));
        end else begin
            n_col = CW'(c0_x + CMPW'(1));
            n_row = r0;
        end
    end

    assign out_ready = !r_o_valid || !i_stall;
    assign s1_go     = r_s1_valid && out_ready;
    assign o_stall   = r_s1_valid && !out_ready;
    assign accept    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // read stage: line store data arrives here in the cycle after acceptance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_emit  <= (r0_x >= CMPW'(2)) && (c0_x >= CMPW'(2));
            r_s1_last  <= (r0_x == rows_e - CMPW'(1)) && (c0_x == cols_e - CMPW'(1));
            r_s1_pix   <= i_pixel;
            r_s1_idx   <= c0;
            r_s1_row   <= r0_m1[POS_OUT_W-1:0];
            r_s1_col   <= c0_m1[POS_OUT_W-1:0];
            // same entry written at this edge: bypass the memory read
            r_fwd      <= s1_go && (r_s1_idx == c0);
            r_fwd_data <= wr_data;
        end
    end

    assign lines          = r_fwd ? r_fwd_data : ls_rd_data;
    assign wr_data.above2 = lines.above;
    assign wr_data.above  = r_s1_pix;
    assign ls_ctl.rd_en   = accept;
    assign ls_ctl.wr_en   = s1_go;

    cen_line_store #(
        .DEPTH (MAX_COLS),
        .AW    (CW)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_ctl     (ls_ctl),
        .i_rd_addr (c0),
        .i_wr_addr (r_s1_idx),
        .i_wr_data (wr_data),
        .o_rd_data (ls_rd_data)
    );

    cen_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (s1_go),
        .i_top   (lines.above2),
        .i_mid   (lines.above),
        .i_bot   (r_s1_pix),
        .o_code  (code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_ready) begin
            r_o_valid <= s1_go && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_emit) begin
            r_o_code <= code;
            r_o_row  <= r_s1_row;
            r_o_col  <= r_s1_col;
            r_o_last <= r_s1_last;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_census_code = r_o_code;
    assign o_center_row  = r_o_row;
    assign o_center_col  = r_o_col;
    assign o_frame_last  = r_o_last;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_o_valid && i_stall && r_s1_valid))
        else $error("input stalled without a blocked result");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_s1_valid && r_s1_emit))
        else $error("result without an emitting item");

    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_center_row != '0 && o_center_col != '0))
        else $error("border center emitted");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_ready) |=> ($stable(r_s1_idx) && $stable(r_s1_pix)))
        else $error("waiting item changed");

endmodule
